// File: design/psi_pkg.sv
package psi_pkg;

	// Default geometry of the inbox.
	localparam int DEF_NUM_SLOTS  = 8;
	localparam int DEF_RING_DEPTH = 16;

	// Configuration port.
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	// Largest number of frames one drain may emit.
	localparam int MAX_DRAIN = 64;

	// Interference scaling: one in Q2.14 and half an output step.
	localparam int LEVEL_ONE   = 16384;
	localparam int LEVEL_ROUND = 8192;

	// Stored descriptor: tag followed by payload length, flags, interference.
	localparam int TAG_W  = 64;
	localparam int INFO_W = 28;
	localparam int WORD_W = TAG_W + INFO_W;

	typedef enum logic [2:0] {
		REG_IS_HOST     = 3'd0,
		REG_HEADER      = 3'd1,
		REG_FRAME_HEAD  = 3'd2,
		REG_MAX_PAYLOAD = 3'd3,
		REG_MAX_PACKET  = 3'd4,
		REG_RADIO_MASK  = 3'd5
	} reg_idx_t;

	typedef enum logic {
		CMD_STORE = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_TOO_SHORT = 3'd2,
		ST_BAD_SLOT  = 3'd3,
		ST_BAD_LEN   = 3'd4
	} status_t;

	typedef struct packed {
		logic        is_host;
		logic [7:0]  header_bytes;
		logic [7:0]  frame_head_bytes;
		logic [11:0] max_payload_bytes;
		logic [11:0] max_packet_bytes;
		logic [7:0]  radio_flag_mask;
	} cfg_t;

	localparam logic        RST_IS_HOST     = 1'b0;
	localparam logic [7:0]  RST_HEADER      = 8'd16;
	localparam logic [7:0]  RST_FRAME_HEAD  = 8'd8;
	localparam logic [11:0] RST_MAX_PAYLOAD = 12'd1000;
	localparam logic [11:0] RST_MAX_PACKET  = 12'd1200;
	localparam logic [7:0]  RST_RADIO_MASK  = 8'd1;

endpackage

// File: design/psi_cfg.sv
module psi_cfg import psi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_host           <= RST_IS_HOST;
			cfg_q.header_bytes      <= RST_HEADER;
			cfg_q.frame_head_bytes  <= RST_FRAME_HEAD;
			cfg_q.max_payload_bytes <= RST_MAX_PAYLOAD;
			cfg_q.max_packet_bytes  <= RST_MAX_PACKET;
			cfg_q.radio_flag_mask   <= RST_RADIO_MASK;
		end else if (wr_en) begin
			case (idx)
				REG_IS_HOST:     cfg_q.is_host           <= pwdata[0];
				REG_HEADER:      cfg_q.header_bytes      <= pwdata[7:0];
				REG_FRAME_HEAD:  cfg_q.frame_head_bytes  <= pwdata[7:0];
				REG_MAX_PAYLOAD: cfg_q.max_payload_bytes <= pwdata[11:0];
				REG_MAX_PACKET:  cfg_q.max_packet_bytes  <= pwdata[11:0];
				REG_RADIO_MASK:  cfg_q.radio_flag_mask   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IS_HOST:     prdata = CFG_DATA_W'(cfg_q.is_host);
			REG_HEADER:      prdata = CFG_DATA_W'(cfg_q.header_bytes);
			REG_FRAME_HEAD:  prdata = CFG_DATA_W'(cfg_q.frame_head_bytes);
			REG_MAX_PAYLOAD: prdata = CFG_DATA_W'(cfg_q.max_payload_bytes);
			REG_MAX_PACKET:  prdata = CFG_DATA_W'(cfg_q.max_packet_bytes);
			REG_RADIO_MASK:  prdata = CFG_DATA_W'(cfg_q.radio_flag_mask);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: design/psi_mem.sv
module psi_mem import psi_pkg::*; #(
	parameter int DEPTH  = DEF_NUM_SLOTS * DEF_RING_DEPTH,
	parameter int ADDR_W = $clog2(DEF_NUM_SLOTS * DEF_RING_DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// The read data holds until the next read, so a stalled result is not lost.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/per_source_drop_oldest_inbox.sv
// Per-source inbox: one ring of frame descriptors for each source slot.
// Commands arrive on the input channel (in_valid / in_ready); results leave
// on the output channel (out_valid / out_ready), each with a last flag that
// marks the final result of its command. Configuration is written through
// the APB-style port; the user must write it only while the block is idle,
// and the block does not enforce this. A store transaction is captured at
// acceptance, then checked, stamped and, if it passes, written to the
// descriptor memory as its status result enters the free output register.
// A drain transaction reads one descriptor per cycle while its read data can
// move on, from the single read port of the descriptor memory; empty slots
// are skipped without a read; each frame goes on through the output register.
// A drain that finds nothing returns a single empty marker.
// Reset clears all ring pointers and the frame count. The descriptor memory
// is not cleared: an entry is only read after it has been written.
// When the receiver stalls, the finished result waits in the output
// register and the pending memory read data is held, so nothing is lost;
// the block takes a new command whenever its sequencer is idle, even while
// the last result of the previous command is still waiting.
module per_source_drop_oldest_inbox import psi_pkg::*; #(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int RING_DEPTH = DEF_RING_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [7:0]            source_slot,
	input  logic [11:0]           packet_len,
	input  logic [11:0]           payload_len,
	input  logic [7:0]            frame_flags,
	input  logic [7:0]            packet_interference,
	input  logic signed [15:0]    level_q14,
	input  logic [63:0]           frame_tag,
	input  logic [6:0]            max_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [2:0]            status,
	output logic                  relay,
	output logic [3:0]            out_slot,
	output logic [63:0]           out_tag,
	output logic [11:0]           out_payload_len,
	output logic [7:0]            out_flags,
	output logic [7:0]            out_interference,
	output logic                  last
);

	localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDX_W    = $clog2(RING_DEPTH);
	localparam int PTR_W    = IDX_W + 1;
	localparam int ENTRIES  = NUM_SLOTS * RING_DEPTH;
	localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TOT_W    = $clog2(ENTRIES + 1);
	localparam int CNT_W    = (TOT_W > 7) ? TOT_W : 7;
	localparam int PTR_LAST = 2 * RING_DEPTH - 1;
	localparam int PTR_MOD  = 2 * RING_DEPTH;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_STORE = 4'b0010,
		S_DRAIN = 4'b0100,
		S_MARK  = 4'b1000
	} state_t;

	// Pointer advance modulo twice the ring depth.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(PTR_LAST)) ? '0 : p + 1'b1;
	endfunction

	// Memory address of the entry a pointer names within a slot's ring.
	function automatic logic [ADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] s,
			input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] idx;
		idx = (p >= PTR_W'(RING_DEPTH)) ? p - PTR_W'(RING_DEPTH) : p;
		return ADDR_W'(s) * ADDR_W'(RING_DEPTH) + ADDR_W'(idx);
	endfunction

	cfg_t cfg;

	state_t state_q;

	// Command captured at acceptance.
	logic [7:0]         in_slot_q;
	logic [11:0]        in_pkt_len_q;
	logic [11:0]        in_pay_len_q;
	logic [7:0]         in_flags_q;
	logic [7:0]         in_intf_q;
	logic signed [15:0] in_level_q;
	logic [63:0]        in_tag_q;

	// Ring pointers and the number of frames held over all slots.
	logic [PTR_W-1:0]  head_q [NUM_SLOTS];
	logic [PTR_W-1:0]  tail_q [NUM_SLOTS];
	logic [TOT_W-1:0]  total_q;

	// Drain sequencer.
	logic [SLOT_W-1:0] scan_q;
	logic [6:0]        remain_q;
	logic              pend_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              last_s1;

	// Output register.
	logic        out_valid_q;
	kind_t       kind_q;
	status_t     status_q;
	logic        relay_q;
	logic [3:0]  slot_q;
	logic [63:0] tag_q;
	logic [11:0] plen_q;
	logic [7:0]  flags_q;
	logic [7:0]  intf_q;
	logic        last_q;

	logic              in_fire;
	logic              out_free;
	logic [SLOT_W-1:0] sel_slot;
	logic [PTR_W-1:0]  head_sel;
	logic [PTR_W-1:0]  tail_sel;
	logic [PTR_W:0]    fill;
	logic              full;
	logic [6:0]        limit;
	logic [6:0]        drain_n;

	logic [8:0]  hdr_sum;
	logic [11:0] body_len;
	logic [12:0] need_len;
	logic [14:0] lvl;
	logic [22:0] scaled;
	logic [7:0]  stamp;
	status_t     st_status;
	logic        st_relay;
	logic [7:0]  st_intf;
	logic        st_ok;

	logic store_fire;
	logic store_write;
	logic can_issue;
	logic issue;
	logic skip;
	logic frame_load;
	logic mark_fire;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	psi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psi_mem #(
		.DEPTH  (ENTRIES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// One pointer pair is looked at per cycle: the stored slot or the scanned one.
	assign sel_slot = (state_q == S_STORE) ? in_slot_q[SLOT_W-1:0] : scan_q;
	assign head_sel = head_q[sel_slot];
	assign tail_sel = tail_q[sel_slot];

	always_comb begin
		if (tail_sel >= head_sel) begin
			fill = {1'b0, tail_sel} - {1'b0, head_sel};
		end else begin
			fill = {1'b0, tail_sel} + (PTR_W + 1)'(PTR_MOD) - {1'b0, head_sel};
		end
		full = (fill >= (PTR_W + 1)'(RING_DEPTH));
	end

	// A drain emits at most the frames held, and at most the requested count capped at MAX_DRAIN.
	always_comb begin
		limit   = (max_count > 7'(MAX_DRAIN)) ? 7'(MAX_DRAIN) : max_count;
		drain_n = (CNT_W'(total_q) < CNT_W'(limit)) ? 7'(total_q) : limit;
	end

	// Interference level clamped to zero..one and scaled to a byte with rounding.
	always_comb begin
		if (in_level_q[15]) begin
			lvl = '0;
		end else if (in_level_q > 16'sd16384) begin
			lvl = 15'(LEVEL_ONE);
		end else begin
			lvl = in_level_q[14:0];
		end
		scaled = {lvl, 8'h00} - 23'(lvl) + 23'(LEVEL_ROUND);
		stamp  = scaled[21:14];
	end

	// Store checks in priority order: too short, bad slot, bad length.
	always_comb begin
		hdr_sum   = {1'b0, cfg.header_bytes} + {1'b0, cfg.frame_head_bytes};
		body_len  = in_pkt_len_q - 12'(cfg.header_bytes);
		need_len  = 13'(cfg.frame_head_bytes) + 13'(in_pay_len_q);
		st_status = ST_STORED;
		st_relay  = 1'b0;
		st_intf   = in_intf_q;
		st_ok     = 1'b0;
		if (in_pkt_len_q < 12'(hdr_sum)) begin
			st_status = ST_TOO_SHORT;
		end else if (in_slot_q >= 8'(NUM_SLOTS)) begin
			st_status = ST_BAD_SLOT;
		end else if (in_pay_len_q > cfg.max_payload_bytes ||
				need_len > {1'b0, body_len}) begin
			st_status = ST_BAD_LEN;
		end else begin
			st_ok = 1'b1;
			if (full) begin
				st_status = ST_DROPPED;
			end
			if (cfg.is_host) begin
				st_relay = (in_pkt_len_q <= cfg.max_packet_bytes);
				st_intf  = ((in_flags_q & cfg.radio_flag_mask) != 8'h00) ? stamp : 8'h00;
			end
		end
	end

	assign store_fire  = (state_q == S_STORE) && out_free;
	assign store_write = store_fire && st_ok;

	// A read is issued only when its data can move on or the slot behind it is free.
	assign can_issue  = (state_q == S_DRAIN) && (remain_q != 7'd0) && (!pend_s1 || out_free);
	assign issue      = can_issue && (head_sel != tail_sel);
	assign skip       = can_issue && (head_sel == tail_sel);
	assign frame_load = pend_s1 && out_free;
	assign mark_fire  = (state_q == S_MARK) && out_free;

	assign mem_we    = store_write;
	assign mem_waddr = ring_addr(in_slot_q[SLOT_W-1:0], tail_sel);
	assign mem_wdata = {in_tag_q, in_pay_len_q, in_flags_q, st_intf};
	assign mem_raddr = ring_addr(scan_q, head_sel);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_slot_q    <= source_slot;
			in_pkt_len_q <= packet_len;
			in_pay_len_q <= payload_len;
			in_flags_q   <= frame_flags;
			in_intf_q    <= packet_interference;
			in_level_q   <= level_q14;
			in_tag_q     <= frame_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			scan_q   <= '0;
			remain_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						scan_q   <= '0;
						remain_q <= drain_n;
						if (cmd_t'(command) == CMD_STORE) begin
							state_q <= S_STORE;
						end else if (drain_n == 7'd0) begin
							state_q <= S_MARK;
						end else begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_STORE: begin
					if (store_fire) begin
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (skip) begin
						scan_q <= scan_q + 1'b1;
					end
					if (issue) begin
						remain_q <= remain_q - 1'b1;
					end
					if (remain_q == 7'd0 && (!pend_s1 || out_free)) begin
						state_q <= S_IDLE;
					end
				end
				S_MARK: begin
					if (mark_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			if (store_write) begin
				tail_q[in_slot_q[SLOT_W-1:0]] <= ptr_inc(tail_sel);
				if (full) begin
					head_q[in_slot_q[SLOT_W-1:0]] <= ptr_inc(head_sel);
				end else begin
					total_q <= total_q + 1'b1;
				end
			end
			if (issue) begin
				head_q[scan_q] <= ptr_inc(head_sel);
				total_q        <= total_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (issue) begin
			pend_s1 <= 1'b1;
		end else if (out_free) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			slot_s1 <= scan_q;
			last_s1 <= (remain_q == 7'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (store_fire || frame_load || mark_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_fire) begin
			kind_q   <= KIND_STATUS;
			status_q <= st_status;
			relay_q  <= st_relay;
			slot_q   <= '0;
			tag_q    <= '0;
			plen_q   <= '0;
			flags_q  <= '0;
			intf_q   <= '0;
			last_q   <= 1'b1;
		end else if (frame_load) begin
			kind_q   <= KIND_FRAME;
			status_q <= ST_STORED;
			relay_q  <= 1'b0;
			slot_q   <= 4'(slot_s1);
			tag_q    <= mem_rdata[WORD_W-1:INFO_W];
			plen_q   <= mem_rdata[27:16];
			flags_q  <= mem_rdata[15:8];
			intf_q   <= mem_rdata[7:0];
			last_q   <= last_s1;
		end else if (mark_fire) begin
			kind_q   <= KIND_EMPTY;
			status_q <= ST_STORED;
			relay_q  <= 1'b0;
			slot_q   <= '0;
			tag_q    <= '0;
			plen_q   <= '0;
			flags_q  <= '0;
			intf_q   <= '0;
			last_q   <= 1'b1;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign status           = status_q;
	assign relay            = relay_q;
	assign out_slot         = slot_q;
	assign out_tag          = tag_q;
	assign out_payload_len  = plen_q;
	assign out_flags        = flags_q;
	assign out_interference = intf_q;
	assign last             = last_q;

	// The frame count never exceeds the total ring capacity.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(ENTRIES))
		else $error("frame count above capacity");

	// While frames remain to be drained, some ring still holds one.
	a_remain_held: assert property (@(posedge clk) disable iff (!arst_n)
		remain_q != 7'd0 && state_q == S_DRAIN |-> total_q != '0)
		else $error("drain count exceeds held frames");

	// Read data that cannot move on stays pending with its slot.
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && !out_free |=> pend_s1 && $stable(slot_s1))
		else $error("pending drain read lost");

	// A rejected store never asks for a relay.
	a_reject_relay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_STATUS && status_q != ST_STORED &&
		status_q != ST_DROPPED |-> !relay_q)
		else $error("relay on rejected store");

	// A drain with nothing left to issue or deliver returns to idle.
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN && remain_q == 7'd0 && !pend_s1 |=> state_q == S_IDLE)
		else $error("drain did not finish");

endmodule
